// ----- rtl/hspd_pkg.sv -----
// Package for the humidity sensor pulse decoder.
// Holds widths, reset values, register indexes and status/model codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hspd_pkg;

  localparam int FRAME_BITS_DEF = 40;
  localparam int DECODE_BITS    = 40;

  localparam int TS_W    = 64;
  localparam int THR_W   = 32;
  localparam int HUM_W   = 11;
  localparam int TEMP_W  = 12;
  localparam int STAT_W  = 2;
  localparam int MODEL_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int OUT_DATA_W = 24;  // humidity + temperature, padded to bytes

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_MODEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_THRESH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_THRESH   = 2'd2;

  // sensor model codes (3 behaves as auto)
  localparam logic [MODEL_W-1:0] MODEL_AUTO   = 2'd0;
  localparam logic [MODEL_W-1:0] MODEL_NARROW = 2'd1;
  localparam logic [MODEL_W-1:0] MODEL_WIDE   = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_GOOD     = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_SUM  = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_DATA = 2'd2;

  // input mode flag
  localparam logic MODE_EDGE    = 1'b0;
  localparam logic MODE_TIMEOUT = 1'b1;

  // reset values
  localparam logic [THR_W-1:0] GAP_THRESH_RST = 32'd1000000;
  localparam logic [THR_W-1:0] ONE_THRESH_RST = 32'd100000;

  // range limits in tenths / raw bytes
  localparam logic [15:0] WIDE_HUM_MAX  = 16'd1100;
  localparam logic [14:0] WIDE_TPOS_MAX = 15'd1350;
  localparam logic [14:0] WIDE_TNEG_MAX = 15'd500;
  localparam logic [7:0]  NAR_TEMP_MAX  = 8'd60;
  localparam logic [7:0]  NAR_HUM_MIN   = 8'd10;
  localparam logic [7:0]  NAR_HUM_MAX   = 8'd90;
  localparam logic [HUM_W-1:0] HUM_LIMIT = 11'd1100;

endpackage

`default_nettype wire

// ----- rtl/humidity_sensor_pulse_decoder_top.sv -----
// Top level of the humidity sensor pulse decoder: edge timing, bit capture,
// frame decode and held readings. Depends on hspd_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Decodes the pulse train of a single-wire humidity/temperature sensor.
// Each slave transaction is either a rising-edge timestamp (tuser = 0) or a
// line timeout (tuser = 1). Edges produce no result; they shift one bit into
// the frame register (1 when the interval since the previous edge exceeds
// one_threshold_ns) or clear it when the interval exceeds gap_threshold_ns.
// A timeout decodes the low 40 bits of the frame and emits exactly one
// result: status in tuser, held humidity and temperature (tenths) in tdata.
// Every transaction is handled by the combinational logic between the input
// handshake and the result register, so one transaction is taken per clock;
// the only stall comes from a result waiting in the output register while
// m_tready is low. Configuration writes belong in idle periods.
module humidity_sensor_pulse_decoder_top #(
  parameter int FRAME_BITS = hspd_pkg::FRAME_BITS_DEF  // 40..64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration write port
  input  wire logic                              cfg_we,
  input  wire logic [hspd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [hspd_pkg::CFG_DATA_W-1:0]   cfg_data,
  // slave stream
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [hspd_pkg::TS_W-1:0]         s_tdata,   // [63:0] timestamp_ns
  input  wire logic [0:0]                        s_tuser,   // [0] mode
  // master stream
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [hspd_pkg::OUT_DATA_W-1:0]        m_tdata,   // [10:0] humidity_tenths,
                                                            // [22:11] temperature_tenths,
                                                            // [23] zero
  output logic [hspd_pkg::STAT_W-1:0]            m_tuser    // [1:0] status
);

  // configuration registers
  logic [hspd_pkg::MODEL_W-1:0] sensor_model;
  logic [hspd_pkg::THR_W-1:0]   gap_threshold_ns;
  logic [hspd_pkg::THR_W-1:0]   one_threshold_ns;

  // decoder state
  logic [hspd_pkg::TS_W-1:0]    last_edge_time;
  logic [FRAME_BITS-1:0]        frame_shift;
  logic [FRAME_BITS-1:0]        frame_shift_next;
  logic [hspd_pkg::HUM_W-1:0]   held_humidity;
  logic [hspd_pkg::HUM_W-1:0]   held_humidity_next;
  logic [hspd_pkg::TEMP_W-1:0]  held_temperature;
  logic [hspd_pkg::TEMP_W-1:0]  held_temperature_next;
  logic [hspd_pkg::STAT_W-1:0]  status_next;

  logic accept;
  logic is_timeout;

  // Output register frees up the same cycle it is drained.
  assign s_tready   = !m_tvalid || m_tready;
  assign accept     = s_tvalid && s_tready;
  assign is_timeout = (s_tuser[0] == hspd_pkg::MODE_TIMEOUT);

  // ---- edge path: modular interval, gap and one-bit compares ----
  logic [hspd_pkg::TS_W-1:0] interval;
  logic                      gap_hit;
  logic                      one_bit;

  assign interval = s_tdata - last_edge_time;
  assign gap_hit  = interval > {{(hspd_pkg::TS_W-hspd_pkg::THR_W){1'b0}}, gap_threshold_ns};
  assign one_bit  = interval > {{(hspd_pkg::TS_W-hspd_pkg::THR_W){1'b0}}, one_threshold_ns};

  always_comb begin
    if (gap_hit) begin
      frame_shift_next = '0;
    end else begin
      frame_shift_next = {frame_shift[FRAME_BITS-2:0], one_bit};
    end
  end

  // ---- timeout path: checksum and format decode ----
  logic [7:0] b0, b1, b2, b3, b4;
  logic [7:0] sum8;
  logic       sum_ok;

  assign b0 = frame_shift[7:0];
  assign b1 = frame_shift[15:8];
  assign b2 = frame_shift[23:16];
  assign b3 = frame_shift[31:24];
  assign b4 = frame_shift[39:32];
  assign sum8   = b1 + b2 + b3 + b4;
  assign sum_ok = (sum8 == b0);

  // narrow integer format: whole units in byte4 / byte2, zero fractions
  logic                        nar_ok;
  logic [hspd_pkg::HUM_W-1:0]  nar_hum;
  logic [hspd_pkg::TEMP_W-1:0] nar_temp;

  assign nar_ok = (b1 == 8'd0) && (b3 == 8'd0) && (b2 <= hspd_pkg::NAR_TEMP_MAX) &&
                  (b4 >= hspd_pkg::NAR_HUM_MIN) && (b4 <= hspd_pkg::NAR_HUM_MAX);
  // x*10 as two shifts; values are small enough that truncation is exact
  assign nar_hum  = {b4, 3'b000} + {2'b00, b4, 1'b0};
  assign nar_temp = {1'b0, b2, 3'b000} + {3'b000, b2, 1'b0};

  // wide format: tenths, temperature in sign-magnitude
  logic [15:0]                 wide_hum_raw;
  logic [14:0]                 wide_mag;
  logic                        wide_neg;
  logic                        wide_ok;
  logic [hspd_pkg::TEMP_W-1:0] wide_temp;

  assign wide_hum_raw = {b4, b3};
  assign wide_mag     = {b2[6:0], b1};
  assign wide_neg     = b2[7];
  assign wide_ok      = (wide_hum_raw <= hspd_pkg::WIDE_HUM_MAX) &&
                        (wide_neg ? (wide_mag <= hspd_pkg::WIDE_TNEG_MAX)
                                  : (wide_mag <= hspd_pkg::WIDE_TPOS_MAX));
  // negative zero comes out as plain zero
  assign wide_temp = wide_neg ? (hspd_pkg::TEMP_W'(0) - wide_mag[hspd_pkg::TEMP_W-1:0])
                              : wide_mag[hspd_pkg::TEMP_W-1:0];

  always_comb begin
    held_humidity_next    = held_humidity;
    held_temperature_next = held_temperature;
    status_next           = hspd_pkg::ST_GOOD;
    if (!sum_ok) begin
      status_next = hspd_pkg::ST_BAD_SUM;
    end else begin
      case (sensor_model)
        hspd_pkg::MODEL_NARROW: begin
          if (nar_ok) begin
            held_humidity_next    = nar_hum;
            held_temperature_next = nar_temp;
          end else begin
            status_next = hspd_pkg::ST_BAD_DATA;
          end
        end
        hspd_pkg::MODEL_WIDE: begin
          if (wide_ok) begin
            held_humidity_next    = wide_hum_raw[hspd_pkg::HUM_W-1:0];
            held_temperature_next = wide_temp;
          end else begin
            status_next = hspd_pkg::ST_BAD_DATA;
          end
        end
        default: begin
          // auto: wide format first, narrow as fallback
          if (wide_ok) begin
            held_humidity_next    = wide_hum_raw[hspd_pkg::HUM_W-1:0];
            held_temperature_next = wide_temp;
          end else if (nar_ok) begin
            held_humidity_next    = nar_hum;
            held_temperature_next = nar_temp;
          end else begin
            status_next = hspd_pkg::ST_BAD_DATA;
          end
        end
      endcase
    end
  end

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_model     <= hspd_pkg::MODEL_AUTO;
      gap_threshold_ns <= hspd_pkg::GAP_THRESH_RST;
      one_threshold_ns <= hspd_pkg::ONE_THRESH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hspd_pkg::REG_SENSOR_MODEL: sensor_model <= cfg_data[hspd_pkg::MODEL_W-1:0];
        hspd_pkg::REG_GAP_THRESH:   gap_threshold_ns <= cfg_data;
        hspd_pkg::REG_ONE_THRESH:   one_threshold_ns <= cfg_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---- state and result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge_time   <= '0;
      frame_shift      <= '0;
      held_humidity    <= '0;
      held_temperature <= '0;
      m_tvalid         <= 1'b0;
    end else begin
      // a new result replaces the one drained this cycle
      if (accept && is_timeout) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept) begin
        if (is_timeout) begin
          frame_shift      <= '0;
          held_humidity    <= held_humidity_next;
          held_temperature <= held_temperature_next;
        end else begin
          last_edge_time <= s_tdata;
          frame_shift    <= frame_shift_next;
        end
      end
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (accept && is_timeout) begin
      m_tuser <= status_next;
      m_tdata <= {1'b0, held_temperature_next, held_humidity_next};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hspd_checker.sv -----
// Port-level checker for the humidity sensor pulse decoder, with its bind.
// Depends on hspd_pkg and humidity_sensor_pulse_decoder_top.
`timescale 1ns / 1ps
`default_nettype none

module hspd_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_tvalid,
  input wire logic                            s_tready,
  input wire logic [0:0]                      s_tuser,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [hspd_pkg::OUT_DATA_W-1:0] m_tdata,
  input wire logic [hspd_pkg::STAT_W-1:0]     m_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // a timeout transaction always leaves a result behind
  a_timeout_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser[0] == hspd_pkg::MODE_TIMEOUT) |=> m_tvalid)
    else $error("timeout transaction produced no result");

  // a new result only follows a timeout transaction
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tuser[0] == hspd_pkg::MODE_TIMEOUT)))
    else $error("result without a timeout transaction");

  // status is a defined code and held humidity stays in range
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tuser == hspd_pkg::ST_GOOD) || (m_tuser == hspd_pkg::ST_BAD_SUM) ||
                  (m_tuser == hspd_pkg::ST_BAD_DATA)) &&
                 (m_tdata[hspd_pkg::HUM_W-1:0] <= hspd_pkg::HUM_LIMIT))
    else $error("result status or humidity out of range");

endmodule

bind humidity_sensor_pulse_decoder_top hspd_checker u_hspd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- verif/humidity_sensor_pulse_decoder_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for humidity_sensor_pulse_decoder_top: streams edge and
// timeout transactions, predicts every decoded reading and checks each result.
// Depends on hspd_pkg and the decoder RTL.

module humidity_sensor_pulse_decoder_top_tb;

  localparam logic [hspd_pkg::MODEL_W-1:0] MODEL_SPARE = 2'd3;  // unassigned, decodes as auto
  localparam int SETTLE_CYCLES = 8;        // block result is registered; margin on top
  localparam int DRAIN_LIMIT   = 100000;   // cycles to wait for outstanding readings
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic                      mode;
    logic [hspd_pkg::TS_W-1:0] stamp;
  } pulse_t;

  typedef struct packed {
    logic [hspd_pkg::STAT_W-1:0] status;
    logic [hspd_pkg::HUM_W-1:0]  hum;
    logic [hspd_pkg::TEMP_W-1:0] temp;
  } reading_t;

  // receiver back-pressure styles
  typedef enum int {RX_OPEN, RX_HALF, RX_MOSTLY, RX_SPARSE} rx_style_t;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            cfg_we    = 1'b0;
  logic [hspd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [hspd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  logic                            s_tvalid  = 1'b0;
  logic                            s_tready;
  logic [hspd_pkg::TS_W-1:0]       s_tdata   = '0;   // [63:0] timestamp_ns
  logic [0:0]                      s_tuser   = '0;   // [0] mode
  logic                            m_tvalid;
  logic                            m_tready  = 1'b0;
  logic [hspd_pkg::OUT_DATA_W-1:0] m_tdata;  // [10:0] humidity, [22:11] temperature, [23] zero
  logic [hspd_pkg::STAT_W-1:0]     m_tuser;  // [1:0] status

  humidity_sensor_pulse_decoder_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Decoder prediction: own copy of configuration and state.
  // ---------------------------------------------------------------------------
  logic [hspd_pkg::MODEL_W-1:0]        model_sel  = hspd_pkg::MODEL_AUTO;
  logic [hspd_pkg::THR_W-1:0]          gap_ns     = hspd_pkg::GAP_THRESH_RST;
  logic [hspd_pkg::THR_W-1:0]          one_ns     = hspd_pkg::ONE_THRESH_RST;
  logic [hspd_pkg::TS_W-1:0]           last_stamp = '0;
  logic [hspd_pkg::FRAME_BITS_DEF-1:0] frame_bits = '0;
  logic [hspd_pkg::HUM_W-1:0]          held_hum   = '0;
  logic [hspd_pkg::TEMP_W-1:0]         held_temp  = '0;

  pulse_t   pulse_queue[$];        // transactions waiting for the driver
  reading_t expected_readings[$];  // predicted readings, oldest first
  int       error_count  = 0;
  int       queued_count = 0;
  logic [hspd_pkg::TS_W-1:0] gen_now = '0;   // stimulus time base, last queued edge

  task automatic log_failure(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got)
      log_failure($sformatf("%s mismatch: expected %0d (0x%0h), got %0d (0x%0h)",
                            name, want, want, got, got));
  endtask

  // Applies one accepted transaction; a timeout yields one reading.
  task automatic predict_reading(input logic mode, input logic [hspd_pkg::TS_W-1:0] stamp);
    logic [hspd_pkg::TS_W-1:0]   interval;
    logic [7:0]                  b [5];
    logic [7:0]                  sum;
    logic [15:0]                 w_hum;
    logic [14:0]                 w_mag;
    logic                        fits_wide, fits_narrow;
    logic [hspd_pkg::HUM_W-1:0]  w_h, n_h;
    logic [hspd_pkg::TEMP_W-1:0] w_t, n_t;
    reading_t                    r;
    if (mode == hspd_pkg::MODE_EDGE) begin
      interval = stamp - last_stamp;  // modular: a backwards stamp looks huge
      last_stamp = stamp;
      if (interval > 64'(gap_ns)) frame_bits = '0;
      else frame_bits = {frame_bits[hspd_pkg::FRAME_BITS_DEF-2:0], interval > 64'(one_ns)};
      return;
    end
    for (int k = 0; k < 5; k++) b[k] = frame_bits[8*k +: 8];
    frame_bits = '0;
    sum = b[1] + b[2] + b[3] + b[4];

    // wide: 16-bit humidity, sign-magnitude temperature
    w_hum = {b[4], b[3]};
    w_mag = {b[2][6:0], b[1]};
    fits_wide = (w_hum <= 16'd1100) && (b[2][7] ? (w_mag <= 15'd500) : (w_mag <= 15'd1350));
    w_h = w_hum[hspd_pkg::HUM_W-1:0];
    // minus zero stays 0
    w_t = b[2][7] ? hspd_pkg::TEMP_W'(-int'(w_mag)) : hspd_pkg::TEMP_W'(w_mag);

    // narrow: whole units in bytes 2 and 4
    fits_narrow = (b[1] == 8'd0) && (b[3] == 8'd0) && (b[2] <= 8'd60) &&
                  (b[4] >= 8'd10) && (b[4] <= 8'd90);
    n_h = hspd_pkg::HUM_W'(b[4] * 10);
    n_t = hspd_pkg::TEMP_W'(b[2] * 10);

    if (sum != b[0]) begin
      r.status = hspd_pkg::ST_BAD_SUM;
    end else if (fits_wide && model_sel != hspd_pkg::MODEL_NARROW) begin
      held_hum = w_h;
      held_temp = w_t;
      r.status = hspd_pkg::ST_GOOD;
    end else if (fits_narrow && model_sel != hspd_pkg::MODEL_WIDE) begin
      held_hum = n_h;
      held_temp = n_t;
      r.status = hspd_pkg::ST_GOOD;
    end else begin
      r.status = hspd_pkg::ST_BAD_DATA;
    end
    r.hum = held_hum;
    r.temp = held_temp;
    expected_readings.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of transactions with random gaps, fed from pulse_queue.
  // Prediction runs on the transaction accepted at this edge.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    pulse_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_reading(s_tuser[0], s_tdata);
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0 || pulse_queue.size() == 0) begin
          if (gap_left > 0) gap_left--;
          s_tvalid <= 1'b0;
        end else begin
          nxt = pulse_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= nxt.stamp;
          s_tuser  <= nxt.mode;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // a quarter of bursts run straight into the next one
            burst_left = $urandom_range(48, 1);
            gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(9, 1);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: changing back-pressure styles plus long hold-offs. The hold-offs
  // at fixed reading counts land mid-phase, while the driver keeps offering,
  // so the output register fills and s_tready drops.
  // ---------------------------------------------------------------------------
  int        rx_stall      = 0;
  int        rx_style_left = 0;
  int        readings_taken = 0;
  rx_style_t rx_style      = RX_OPEN;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        readings_taken++;
        if (readings_taken == 5 || readings_taken == 30) rx_stall = 500;
      end
      if (rx_stall == 0 && $urandom_range(1999, 0) == 0) rx_stall = $urandom_range(300, 50);
      if (rx_style_left == 0) begin
        rx_style = rx_style_t'($urandom_range(3, 0));
        rx_style_left = $urandom_range(200, 20);
      end else begin
        rx_style_left--;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        m_tready <= 1'b0;
      end else begin
        case (rx_style)
          RX_OPEN:   m_tready <= 1'b1;
          RX_HALF:   m_tready <= 1'($urandom_range(1, 0));
          RX_MOSTLY: m_tready <= ($urandom_range(3, 0) != 0);
          default:   m_tready <= ($urandom_range(3, 0) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each result transaction against the oldest predicted reading.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    reading_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_readings.size() == 0) begin
        log_failure($sformatf("unexpected reading: status %0d tdata 0x%0h", m_tuser, m_tdata));
      end else begin
        want = expected_readings.pop_front();
        check_field("status", want.status, m_tuser);
        check_field("humidity", want.hum, m_tdata[hspd_pkg::HUM_W-1:0]);
        check_field("temperature", want.temp, m_tdata[hspd_pkg::HUM_W +: hspd_pkg::TEMP_W]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_pulse(input logic mode, input logic [hspd_pkg::TS_W-1:0] stamp);
    pulse_queue.push_back('{mode, stamp});
    queued_count++;
    if (mode == hspd_pkg::MODE_EDGE) gen_now = stamp;
  endtask

  // timestamp is don't-care on a timeout; fill it with noise
  task automatic queue_timeout();
    queue_pulse(hspd_pkg::MODE_TIMEOUT, {$urandom, $urandom});
  endtask

  // {byte4, byte3, byte2, byte1, checksum}
  function automatic logic [39:0] pack_frame(input logic [7:0] b1, b2, b3, b4);
    logic [7:0] sum;
    sum = b1 + b2 + b3 + b4;
    return {b4, b3, b2, b1, sum};
  endfunction

  function automatic logic [39:0] wide_frame(input int hum, input int temp);
    logic [15:0] h;
    logic [14:0] mag;
    h = 16'(hum);
    mag = 15'((temp < 0) ? -temp : temp);
    return pack_frame(mag[7:0], {temp < 0, mag[14:8]}, h[7:0], h[15:8]);
  endfunction

  // Interval for one bit, with the threshold boundaries hit now and then.
  // A one is only possible when the one-threshold lies below the gap.
  function automatic logic [63:0] pick_interval(input logic one_bit);
    logic [31:0] lim;
    lim = (one_ns < gap_ns) ? one_ns : gap_ns;
    if (one_bit && one_ns < gap_ns) begin
      case ($urandom_range(7, 0))
        0:       return 64'(one_ns) + 64'd1;
        1:       return 64'(gap_ns);
        default: return 64'($urandom_range(gap_ns, one_ns + 32'd1));
      endcase
    end
    if ($urandom_range(7, 0) == 0) return 64'(lim);
    return 64'($urandom_range(lim, 0));
  endfunction

  // Gap edge to restart capture, nbits edges MSB first, then the timeout.
  task automatic send_frame(input logic [63:0] bits, input int nbits);
    queue_pulse(hspd_pkg::MODE_EDGE,
                gen_now + 64'(gap_ns) + 64'd1 + 64'($urandom_range(1000, 0)));
    for (int i = nbits - 1; i >= 0; i--)
      queue_pulse(hspd_pkg::MODE_EDGE, gen_now + pick_interval(bits[i]));
    queue_timeout();
  endtask

  task automatic send_random_frame();
    logic [39:0] body;
    logic [63:0] bits;
    int          nbits;
    case ($urandom_range(9, 0))
      0, 1, 2: body = wide_frame($urandom_range(1100, 0), int'($urandom_range(1850, 0)) - 500);
      3, 4:    body = pack_frame(8'd0, 8'($urandom_range(60, 0)), 8'd0,
                                 8'($urandom_range(90, 10)));
      5: begin
        body = wide_frame($urandom_range(1100, 0), int'($urandom_range(1850, 0)) - 500);
        body[7:0] = body[7:0] ^ 8'($urandom_range(255, 1));
      end
      6: begin
        case ($urandom_range(2, 0))
          0:       body = wide_frame($urandom_range(65535, 1101), 0);
          1:       body = wide_frame(0, $urandom_range(32767, 1351));
          default: body = wide_frame(0, -int'($urandom_range(32767, 501)));
        endcase
      end
      7: body = pack_frame(8'd0, 8'($urandom), 8'd0, 8'($urandom));
      8: body = pack_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      default: body = 40'({$urandom, $urandom});
    endcase
    bits = {$urandom, $urandom};
    bits[39:0] = body;
    // mostly full frames; some overlong (high bits fall off), some short
    case ($urandom_range(7, 0))
      0:       nbits = $urandom_range(64, 41);
      1:       nbits = $urandom_range(39, 1);
      default: nbits = 40;
    endcase
    send_frame(bits, nbits);
  endtask

  task automatic send_noise();
    case ($urandom_range(3, 0))
      0: queue_pulse(hspd_pkg::MODE_EDGE, {$urandom, $urandom});
      1: repeat ($urandom_range(4, 1)) queue_timeout();
      2: begin
        repeat ($urandom_range(6, 1))
          queue_pulse(hspd_pkg::MODE_EDGE, gen_now + pick_interval(1'($urandom_range(1, 0))));
        queue_timeout();
      end
      default: queue_timeout();
    endcase
  endtask

  // Sender holds off until the queue is drained and every reading is in,
  // then lets the block settle.
  task automatic wait_idle();
    int guard;
    guard = 0;
    @(negedge clk);
    while ((pulse_queue.size() != 0 || s_tvalid || expected_readings.size() != 0) &&
           guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    if (guard >= DRAIN_LIMIT)
      log_failure($sformatf("%0d readings never arrived", expected_readings.size()));
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [hspd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hspd_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      hspd_pkg::REG_SENSOR_MODEL: model_sel = value[hspd_pkg::MODEL_W-1:0];
      hspd_pkg::REG_GAP_THRESH:   gap_ns = value;
      hspd_pkg::REG_ONE_THRESH:   one_ns = value;
      default: ;
    endcase
  endtask

  task automatic run_phase(input logic [hspd_pkg::MODEL_W-1:0] model,
                           input logic [hspd_pkg::THR_W-1:0] gap,
                           input logic [hspd_pkg::THR_W-1:0] one, input int n_items);
    int start;
    wait_idle();
    write_reg(hspd_pkg::REG_SENSOR_MODEL, hspd_pkg::CFG_DATA_W'(model));
    write_reg(hspd_pkg::REG_GAP_THRESH, gap);
    write_reg(hspd_pkg::REG_ONE_THRESH, one);
    @(negedge clk);
    start = queued_count;
    while (queued_count - start < n_items) begin
      if ($urandom_range(99, 0) < 60) send_random_frame();
      else send_noise();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] g;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed transactions, reset thresholds (gap 1e6, one 1e5, auto model).
    queue_pulse(hspd_pkg::MODE_EDGE, 64'd500);      // first edge: interval counted from zero
    queue_pulse(hspd_pkg::MODE_EDGE, 64'd150500);   // one bit
    queue_timeout();                                // frame 0b01: checksum fails
    queue_timeout();                                // empty frame decodes as 0 / 0
    queue_pulse(hspd_pkg::MODE_EDGE, '1);           // all-ones stamp, huge interval clears
    queue_pulse(hspd_pkg::MODE_EDGE, 64'd0);        // wraps around to an interval of one
    queue_pulse(hspd_pkg::MODE_EDGE, 64'd5);
    queue_pulse(hspd_pkg::MODE_EDGE, 64'd2);        // backwards stamp restarts capture
    queue_pulse(hspd_pkg::MODE_TIMEOUT, '1);
    queue_pulse(hspd_pkg::MODE_EDGE, 64'd1000002);  // exactly the gap: kept, one bit
    queue_pulse(hspd_pkg::MODE_EDGE, 64'd1100002);  // exactly the one-threshold: zero bit
    queue_pulse(hspd_pkg::MODE_EDGE, 64'd1200003);  // one above it: one bit
    queue_pulse(hspd_pkg::MODE_EDGE, 64'd2200004);  // one above the gap: clears
    queue_pulse(hspd_pkg::MODE_EDGE, 64'd2200004);  // zero interval
    queue_timeout();

    // Directed frames: range limits, formats, bad checksum, long frame.
    send_frame(64'(wide_frame(1100, 1350)), 40);
    send_frame(64'(wide_frame(0, -500)), 40);
    send_frame(64'(pack_frame(8'h00, 8'h80, 8'h2b, 8'h02)), 40);  // minus zero temperature
    send_frame(64'(wide_frame(1101, 0)), 40);
    send_frame(64'(wide_frame(0, -501)), 40);
    send_frame(64'(wide_frame(0, 1351)), 40);
    send_frame(64'(pack_frame(8'd0, 8'd0, 8'd0, 8'd10)), 40);
    send_frame(64'(pack_frame(8'd0, 8'd60, 8'd0, 8'd90)), 40);
    send_frame(64'(pack_frame(8'd0, 8'd61, 8'd0, 8'd50)), 40);
    send_frame(64'(pack_frame(8'd0, 8'd20, 8'd0, 8'd9)), 40);
    send_frame(64'(pack_frame(8'd0, 8'd20, 8'd0, 8'd91)), 40);
    send_frame(64'(wide_frame(555, -123) ^ 40'h01), 40);         // checksum off by one
    send_frame({24'hc35a96, wide_frame(432, 217)}, 64);          // only low 40 bits count

    // Register settings, extremes included; each phase drains before the writes.
    run_phase(hspd_pkg::MODEL_NARROW, 32'd1000000, 32'd100000, 100);
    run_phase(hspd_pkg::MODEL_WIDE, 32'd5000, 32'd2000, 120);
    run_phase(MODEL_SPARE, 32'hffff_ffff, 32'd0, 100);
    run_phase(hspd_pkg::MODEL_AUTO, 32'd0, 32'hffff_ffff, 50);    // every bit is a zero
    run_phase(hspd_pkg::MODEL_AUTO, 32'd1000000, 32'd100000, 150);
    g = $urandom_range(3000000, 2000);
    run_phase(hspd_pkg::MODEL_W'($urandom_range(3, 0)), g, $urandom_range(g - 1, 0), 120);
    g = $urandom_range(32'hffff_ffff, 1);
    run_phase(hspd_pkg::MODEL_W'($urandom_range(3, 0)), g, $urandom_range(g - 1, 0), 100);

    wait_idle();
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/hspd_pkg.sv
rtl/humidity_sensor_pulse_decoder_top.sv
rtl/hspd_checker.sv
verif/humidity_sensor_pulse_decoder_top_tb.sv
